// File: hw/rtl/isom_pkg.sv
// ----------------------------------------------------------------------------
// isom_pkg: shared types, constants and helpers of the sine oscillator mixer
// Holds the payload structs, the quarter-wave sine table built at
// elaboration, and the saturating Q31 add.
// ----------------------------------------------------------------------------
package isom_pkg;

   // table geometry
   localparam int TABLE_DEPTH = 1024;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int QUARTER     = TABLE_DEPTH / 4;
   localparam int QIDX_W      = IDX_W - 1;
   localparam int FRAC_W      = 32 - IDX_W;

   // q31 limits
   localparam logic signed [31:0] Q31_MAX = 32'sh7fff_ffff;
   localparam logic signed [31:0] Q31_MIN = 32'sh8000_0000;

   // configuration register indexes
   localparam logic REG_PHASE_INC = 1'b0;
   localparam logic REG_AMPLITUDE = 1'b1;

   // polynomial constants, unsigned q30
   localparam logic [63:0] Q30_ONE     = 64'd1073741824;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   typedef struct packed {
      logic signed [31:0] mix_in_0;
      logic signed [31:0] mix_in_1;
      logic signed [31:0] mix_in_2;
      logic signed [31:0] mix_in_3;
   } mix_req_type;

   typedef struct packed {
      logic signed [31:0] mix_out_0;
      logic signed [31:0] mix_out_1;
      logic signed [31:0] mix_out_2;
      logic signed [31:0] mix_out_3;
   } mix_rsp_type;

   // magnitude of one quarter period, both ends included
   typedef logic [30:0] qtab_type [0:QUARTER];

   // sine magnitude of a first-quadrant phase r (q30 of a quarter turn)
   function automatic logic [30:0] quarter_sine(input logic [63:0] r);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] s;
      x  = (r * HALF_PI_Q30) >> 30;
      x2 = (x * x) >> 30;
      t  = Q30_ONE;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd156;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd110;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
      s  = ((x * t) >> 30) << 1;
      if (s > 64'h7fff_ffff) begin
         s = 64'h7fff_ffff;
      end
      return s[30:0];
   endfunction

   function automatic qtab_type build_quarter();
      qtab_type tab;
      for (int i = 0; i <= QUARTER; i++) begin
         tab[i] = quarter_sine(64'(i) << (32 - IDX_W));
      end
      return tab;
   endfunction

   localparam qtab_type QUARTER_ROM = build_quarter();

   // signed 32-bit add clamped to the q31 range
   function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
      logic signed [32:0] s;
      s = {a[31], a} + {b[31], b};
      if (s[32] != s[31]) begin
         return s[32] ? Q31_MIN : Q31_MAX;
      end
      return s[31:0];
   endfunction

endpackage

// File: hw/rtl/isom_sine_lookup.sv
// ----------------------------------------------------------------------------
// isom_sine_lookup: full-period sine entry from the quarter-wave table
// Folds a table index into the first quadrant, reads the magnitude and
// restores the sign of the second half period.
// ----------------------------------------------------------------------------
module isom_sine_lookup (
   input  logic [isom_pkg::IDX_W-1:0] index,
   output logic signed [31:0]         value
);
   import isom_pkg::*;

   logic [QIDX_W-1:0] low;
   logic [QIDX_W-1:0] qidx;
   logic [30:0]       mag;

   // mirror odd quadrants, the quarter point itself lands on the last entry
   always_comb begin
      low = {1'b0, index[IDX_W-3:0]};
      if (index[IDX_W-2]) begin
         qidx = QIDX_W'(QUARTER) - low;
      end else begin
         qidx = low;
      end
      mag = QUARTER_ROM[qidx];
      if (index[IDX_W-1]) begin
         value = -$signed({1'b0, mag});
      end else begin
         value = $signed({1'b0, mag});
      end
   end

endmodule

// File: hw/rtl/isom_q31_mul.sv
// ----------------------------------------------------------------------------
// isom_q31_mul: shared q31 multiplier
// Registers the full 64-bit product each cycle and presents it as a q31
// value, floor of the product over 2^31, with minus one squared clamped.
// ----------------------------------------------------------------------------
module isom_q31_mul (
   input  logic               clock,
   input  logic signed [31:0] op_a,
   input  logic signed [31:0] op_b,
   output logic signed [31:0] q_out
);
   import isom_pkg::*;

   logic signed [63:0] prod_ff;
   logic signed [63:0] prod_in;
   logic               sat_ff;
   logic               sat_in;

   // multiply and flag the one overflowing operand pair
   always_comb begin
      prod_in = op_a * op_b;
      sat_in  = (op_a == Q31_MIN) && (op_b == Q31_MIN);
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      sat_ff  <= sat_in;
   end

   assign q_out = sat_ff ? Q31_MAX : prod_ff[62:31];

endmodule

// File: hw/rtl/interpolated_sine_oscillator_mixer_unit.sv
// ----------------------------------------------------------------------------
// interpolated_sine_oscillator_mixer_unit: sine oscillator mixed into channels
// Phase accumulator, interpolated quarter-wave sine lookup, amplitude
// scaling through one shared multiplier, and saturating mix into four
// channel samples.
//
//   port group   dir   handshake           payload
//   req_*        in    req_valid/req_stall req_data (mix_req_type)
//   rsp_*        out   rsp_valid/rsp_stall rsp_data (mix_rsp_type)
//   apb          in    psel/penable/pready paddr, pwdata, prdata
//
// Each beat steps from acceptance to the result register through one
// table read, two weighted products, the sum, the amplitude pass and the
// mix, all products through the single multiplier. No new beat is taken
// until the sequencer has left the mix and returned to idle.
// req_stall stays high while a beat is in work and while the mix waits on a
// stalled result. Reset clears the phase, both registers and the sequencer;
// the sine table is constant.
// ----------------------------------------------------------------------------
module interpolated_sine_oscillator_mixer_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  isom_pkg::mix_req_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output isom_pkg::mix_rsp_type rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [2:0]            paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);
   import isom_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_LOOK  = 3'd1;
   localparam logic [2:0] ST_MUL_A = 3'd2;
   localparam logic [2:0] ST_MUL_B = 3'd3;
   localparam logic [2:0] ST_SUM   = 3'd4;
   localparam logic [2:0] ST_MUL_C = 3'd5;
   localparam logic [2:0] ST_MIX   = 3'd6;

   logic [2:0]         state_ff, state_in;
   logic [31:0]        inc_ff, inc_in;
   logic signed [31:0] amp_ff, amp_in;
   logic [31:0]        phase_ff, phase_in;
   mix_req_type        mix_ff, mix_in;
   logic signed [31:0] va_ff, va_in;
   logic signed [31:0] vb_ff, vb_in;
   logic signed [31:0] sum_ff, sum_in;
   logic               rsp_valid_ff, rsp_valid_in;
   mix_rsp_type        rsp_data_ff, rsp_data_in;

   logic               req_take;
   logic               csr_write;
   logic [IDX_W-1:0]   idx_a;
   logic [IDX_W-1:0]   idx_b;
   logic [30:0]        wt_b;
   logic [30:0]        wt_a;
   logic signed [31:0] sine_a;
   logic signed [31:0] sine_b;
   logic signed [31:0] op_a;
   logic signed [31:0] op_b;
   logic signed [31:0] mul_q;
   logic               out_free;

   // register port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign prdata    = (paddr[2] == REG_AMPLITUDE) ? amp_ff : inc_ff;

   always_comb begin
      inc_in = inc_ff;
      amp_in = amp_ff;
      if (csr_write) begin
         case (paddr[2])
            REG_PHASE_INC: inc_in = pwdata;
            REG_AMPLITUDE: amp_in = pwdata;
            default: ;
         endcase
      end
   end

   // table indexes and interpolation weights from the phase
   assign idx_a = phase_ff[31 -: IDX_W];
   assign idx_b = idx_a + 1'b1;
   assign wt_b  = {phase_ff[FRAC_W-1:0], {(IDX_W-1){1'b0}}};
   assign wt_a  = ~wt_b;

   isom_sine_lookup u_look_a (
      .index (idx_a),
      .value (sine_a)
   );

   isom_sine_lookup u_look_b (
      .index (idx_b),
      .value (sine_b)
   );

   // operand select for the shared multiplier
   always_comb begin
      case (state_ff)
         ST_MUL_A: begin
            op_a = va_ff;
            op_b = $signed({1'b0, wt_a});
         end
         ST_MUL_B: begin
            op_a = vb_ff;
            op_b = $signed({1'b0, wt_b});
         end
         default: begin
            op_a = amp_ff;
            op_b = sum_ff;
         end
      endcase
   end

   isom_q31_mul u_mul (
      .clock (clock),
      .op_a  (op_a),
      .op_b  (op_b),
      .q_out (mul_q)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // sequencer and datapath
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      mix_in       = mix_ff;
      va_in        = va_ff;
      vb_in        = vb_ff;
      sum_in       = sum_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               phase_in = phase_ff + inc_ff;
               mix_in   = req_data;
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            va_in    = sine_a >>> 1;
            vb_in    = sine_b >>> 1;
            state_in = ST_MUL_A;
         end
         ST_MUL_A: begin
            state_in = ST_MUL_B;
         end
         ST_MUL_B: begin
            sum_in   = mul_q;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            sum_in   = sat_add(sum_ff, mul_q);
            state_in = ST_MUL_C;
         end
         ST_MUL_C: begin
            state_in = ST_MIX;
         end
         ST_MIX: begin
            if (out_free) begin
               rsp_data_in.mix_out_0 = sat_add(mix_ff.mix_in_0, mul_q);
               rsp_data_in.mix_out_1 = sat_add(mix_ff.mix_in_1, mul_q);
               rsp_data_in.mix_out_2 = sat_add(mix_ff.mix_in_2, mul_q);
               rsp_data_in.mix_out_3 = sat_add(mix_ff.mix_in_3, mul_q);
               rsp_valid_in          = 1'b1;
               state_in              = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         inc_ff       <= '0;
         amp_ff       <= '0;
         phase_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         inc_ff       <= inc_in;
         amp_ff       <= amp_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      mix_ff      <= mix_in;
      va_ff       <= va_in;
      vb_ff       <= vb_in;
      sum_ff      <= sum_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
